// ===== src/csfd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the clap-switched fading dimmer: payload structs, register
// map, command codes, clap timing limits and reset values. No dependencies.
package csfd_pkg;

   localparam int TIME_BITS_DEFAULT = 32;

   // APB register map: register i lies at byte address 4*i.
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [2:0] REG_BRIGHTNESS_MAX = 3'd0;
   localparam logic [2:0] REG_FADE_STEP      = 3'd1;
   localparam logic [2:0] REG_FADE_PERIOD    = 3'd2;
   localparam logic [2:0] REG_SAMPLE_PERIOD  = 3'd3;
   localparam logic [2:0] REG_CLAP_ENABLE    = 3'd4;
   localparam logic [2:0] REG_MUSIC_MODE     = 3'd5;

   localparam logic [7:0]  BRIGHTNESS_MAX_RESET = 8'd128;
   localparam logic [7:0]  FADE_STEP_RESET      = 8'd5;
   localparam logic [15:0] FADE_PERIOD_RESET    = 16'd20;
   localparam logic [15:0] SAMPLE_PERIOD_RESET  = 16'd5;
   localparam logic        CLAP_ENABLE_RESET    = 1'b1;
   localparam logic        MUSIC_MODE_RESET     = 1'b0;

   // Light commands carried in the mode field.
   localparam logic [1:0] MODE_NONE   = 2'd0;
   localparam logic [1:0] MODE_ON     = 2'd1;
   localparam logic [1:0] MODE_OFF    = 2'd2;
   localparam logic [1:0] MODE_TOGGLE = 2'd3;

   // Clap pattern gap limits in milliseconds (all bounds exclusive).
   localparam int CLAP_GAP0_MIN = 1000;
   localparam int CLAP_GAP1_MIN = 400;
   localparam int CLAP_GAP1_MAX = 900;
   localparam int CLAP_GAP2_MIN = 50;
   localparam int CLAP_GAP2_MAX = 450;

   typedef struct packed {
      logic [1:0] mode;
      logic       peak_level;
      logic       front_closed;
   } req_type;

   typedef struct packed {
      logic [7:0] brightness;
      logic       light_on;
      logic       frame_update;
      logic       clap_match;
      logic       clap_toggled;
   } rsp_type;

   // Signed fade velocity for a switch on (up) or switch off.
   function automatic logic [8:0] fade_velocity(input logic up, input logic [7:0] step);
      logic [8:0] mag;
      mag = {1'b0, step};
      return up ? mag : 9'(~mag + 9'd1);
   endfunction

endpackage

// ===== src/clap_switch_fading_dimmer.sv =====
`timescale 1ns / 1ps
// Clap-switched fading dimmer: one millisecond tick per request, one
// response per tick. Depends on csfd_pkg.
//
// Each request is one millisecond tick and yields exactly one response. The
// whole tick (counter, command, fade step and clap detection over the
// four-entry timestamp history) is evaluated combinationally from the state
// registers and written into the response register, which decouples the two
// channels: one tick is taken every clock cycle while the response register
// is empty or is being drained that cycle, and the response appears in the
// cycle after acceptance. The user must write registers over the APB-style
// port only while no tick is in flight; the block does not enforce this.
module clap_switch_fading_dimmer
   import csfd_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [7:0]  brightness_max_ff;
   logic [7:0]  fade_step_ff;
   logic [15:0] fade_period_ff;
   logic [15:0] sample_period_ff;
   logic        clap_enable_ff;
   logic        music_mode_ff;

   logic [TIME_BITS-1:0] ms_count_ff, ms_count_in;
   logic [TIME_BITS-1:0] fade_mark_ff, fade_mark_in;
   logic [TIME_BITS-1:0] sample_mark_ff, sample_mark_in;
   logic [TIME_BITS-1:0] history_ff [4];
   logic [TIME_BITS-1:0] history_in [4];
   logic [8:0]  velocity_ff, velocity_in;
   logic [7:0]  level_ff, level_in;
   logic        is_on_ff, is_on_in;
   logic        last_peak_ff, last_peak_in;

   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   logic        req_fire;
   logic        csr_write;
   logic [2:0]  csr_index;

   logic [TIME_BITS-1:0] fade_elapsed, sample_elapsed;
   logic [TIME_BITS-1:0] gap0, gap1, gap2;
   logic        fade_tick, sample_tick, rising, pattern_ok, clap_toggle;
   logic        cmd_on;
   logic [8:0]  cmd_velocity;
   logic [9:0]  level_sum;
   logic [7:0]  fade_level;
   logic [8:0]  fade_vel;
   logic        vel_pos, vel_neg;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------- CSRs
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_max_ff <= BRIGHTNESS_MAX_RESET;
         fade_step_ff      <= FADE_STEP_RESET;
         fade_period_ff    <= FADE_PERIOD_RESET;
         sample_period_ff  <= SAMPLE_PERIOD_RESET;
         clap_enable_ff    <= CLAP_ENABLE_RESET;
         music_mode_ff     <= MUSIC_MODE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_BRIGHTNESS_MAX: brightness_max_ff <= csr_pwdata[7:0];
            REG_FADE_STEP:      fade_step_ff      <= csr_pwdata[7:0];
            REG_FADE_PERIOD:    fade_period_ff    <= csr_pwdata[15:0];
            REG_SAMPLE_PERIOD:  sample_period_ff  <= csr_pwdata[15:0];
            REG_CLAP_ENABLE:    clap_enable_ff    <= csr_pwdata[0];
            REG_MUSIC_MODE:     music_mode_ff     <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_BRIGHTNESS_MAX: csr_prdata = CSR_DATA_BITS'(brightness_max_ff);
         REG_FADE_STEP:      csr_prdata = CSR_DATA_BITS'(fade_step_ff);
         REG_FADE_PERIOD:    csr_prdata = CSR_DATA_BITS'(fade_period_ff);
         REG_SAMPLE_PERIOD:  csr_prdata = CSR_DATA_BITS'(sample_period_ff);
         REG_CLAP_ENABLE:    csr_prdata = CSR_DATA_BITS'(clap_enable_ff);
         REG_MUSIC_MODE:     csr_prdata = CSR_DATA_BITS'(music_mode_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // ----------------------------------------------------------- tick logic
   always_comb begin
      ms_count_in = ms_count_ff + TIME_BITS'(1);

      // The command is applied before the fade step looks at the velocity.
      cmd_on       = 1'b0;
      cmd_velocity = velocity_ff;
      is_on_in     = is_on_ff;
      unique case (req_data.mode)
         MODE_ON:     begin cmd_on = 1'b1; is_on_in = 1'b1; end
         MODE_OFF:    begin cmd_on = 1'b0; is_on_in = 1'b0; end
         MODE_TOGGLE: begin cmd_on = !is_on_ff; is_on_in = !is_on_ff; end
         default:     ;
      endcase
      if (req_data.mode != MODE_NONE) begin
         cmd_velocity = fade_velocity(cmd_on, fade_step_ff);
      end

      // Fade step.
      fade_elapsed = ms_count_in - fade_mark_ff;
      fade_tick    = fade_elapsed > TIME_BITS'(fade_period_ff);
      vel_pos      = (cmd_velocity != '0) && !cmd_velocity[8];
      vel_neg      = cmd_velocity[8];
      level_sum    = {2'b00, level_ff} + {cmd_velocity[8], cmd_velocity};
      fade_level   = level_ff;
      fade_vel     = cmd_velocity;
      if (vel_pos) begin
         if (level_sum >= {2'b00, brightness_max_ff}) begin
            fade_level = brightness_max_ff;
            fade_vel   = '0;
         end else begin
            fade_level = level_sum[7:0];
         end
      end else if (vel_neg) begin
         if (level_sum[9] || level_sum == '0) begin
            fade_level = '0;
            fade_vel   = '0;
         end else begin
            fade_level = level_sum[7:0];
         end
      end else if (is_on_in) begin
         fade_level = brightness_max_ff;
      end
      level_in     = fade_tick ? fade_level : level_ff;
      velocity_in  = fade_tick ? fade_vel : cmd_velocity;
      fade_mark_in = fade_tick ? ms_count_in : fade_mark_ff;

      // Peak sampling and clap detection; gaps are taken over the shifted history.
      sample_elapsed = ms_count_in - sample_mark_ff;
      sample_tick    = sample_elapsed > TIME_BITS'(sample_period_ff);
      rising         = sample_tick && req_data.peak_level && !last_peak_ff;
      gap0 = history_ff[2] - history_ff[1];
      gap1 = history_ff[3] - history_ff[2];
      gap2 = ms_count_in - history_ff[3];
      pattern_ok = (gap0 > TIME_BITS'(CLAP_GAP0_MIN))
                && (gap1 > TIME_BITS'(CLAP_GAP1_MIN)) && (gap1 < TIME_BITS'(CLAP_GAP1_MAX))
                && (gap2 > TIME_BITS'(CLAP_GAP2_MIN)) && (gap2 < TIME_BITS'(CLAP_GAP2_MAX));
      clap_toggle = rising && pattern_ok && clap_enable_ff && !music_mode_ff
                 && req_data.front_closed;

      for (int i = 0; i < 4; i++) begin
         history_in[i] = history_ff[i];
      end
      if (rising) begin
         history_in[0] = history_ff[1];
         history_in[1] = history_ff[2];
         history_in[2] = history_ff[3];
         history_in[3] = ms_count_in;
      end
      last_peak_in   = sample_tick ? req_data.peak_level : last_peak_ff;
      sample_mark_in = sample_tick ? ms_count_in : sample_mark_ff;

      if (clap_toggle) begin
         velocity_in = fade_velocity(!is_on_in, fade_step_ff);
         is_on_in    = !is_on_in;
      end

      rsp_in.brightness   = level_in;
      rsp_in.light_on     = is_on_in;
      rsp_in.frame_update = fade_tick;
      rsp_in.clap_match   = rising && pattern_ok;
      rsp_in.clap_toggled = clap_toggle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_count_ff    <= '0;
         fade_mark_ff   <= '0;
         sample_mark_ff <= '0;
         velocity_ff    <= '0;
         level_ff       <= '0;
         is_on_ff       <= 1'b0;
         last_peak_ff   <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            history_ff[i] <= '0;
         end
      end else if (req_fire) begin
         ms_count_ff    <= ms_count_in;
         fade_mark_ff   <= fade_mark_in;
         sample_mark_ff <= sample_mark_in;
         velocity_ff    <= velocity_in;
         level_ff       <= level_in;
         is_on_ff       <= is_on_in;
         last_peak_ff   <= last_peak_in;
         for (int i = 0; i < 4; i++) begin
            history_ff[i] <= history_in[i];
         end
      end
   end

   // Response register: filled on each accepted transaction, emptied when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // ----------------------------------------------------------- assertions
   // A non-zero fade velocity always points the way the light was last switched.
   a_velocity_sign: assert property (@(posedge clock) disable iff (reset)
      (velocity_ff != '0) |-> (velocity_ff[8] == !is_on_ff))
      else $error("fade velocity sign disagrees with light state");

   a_toggle_needs_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.clap_toggled) |-> rsp_ff.clap_match)
      else $error("clap toggle without a pattern match");

   a_fire_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted transaction produced no response");

   a_ms_advances: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (ms_count_ff == $past(ms_count_ff) + TIME_BITS'(1)))
      else $error("millisecond counter did not advance by one");

endmodule
